### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSCE_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WSCE_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/wsce_pkg.sv
// types, constants and helper functions of the second-write coset encoder
package wsce_pkg;

  localparam int CELLS = 18;
  localparam int FIXED = 5;
  localparam int FREE  = CELLS - FIXED;
  localparam int SYM_W = FREE;

  // parity column of each cell
  localparam logic [SYM_W-1:0] PARITY_COLS [0:CELLS-1] = '{
    13'h13DE, 13'h051B, 13'h0106, 13'h0A9E, 13'h0154, 13'h0379, 13'h1C64, 13'h1667, 13'h19BF,
    13'h0F53, 13'h0AC1, 13'h0414, 13'h10C9, 13'h1EC9, 13'h008F, 13'h1EA1, 13'h13E6, 13'h0B3B
  };

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_MASK = 2'd1,
    STATUS_SINGULAR = 2'd2
  } status_t;

  // one equation: coefficient bits below FREE, right-hand side at bit FREE
  typedef logic [FREE:0] row_t;
  typedef row_t [FREE-1:0] mat_t;

  typedef struct packed {
    mat_t m;
    logic ok;
  } elim_t;

  // xor of the parity columns of the set cells
  function automatic logic [SYM_W-1:0] syndrome(logic [CELLS-1:0] pat);
    logic [SYM_W-1:0] s;
    s = '0;
    for (int j = 0; j < CELLS; j++) begin
      if (pat[j]) s = s ^ PARITY_COLS[j];
    end
    return s;
  endfunction

  // rank of a free cell among the free cells below it
  function automatic logic [4:0] free_rank(logic [CELLS-1:0] mask, int j);
    logic [CELLS-1:0] low;
    low = ~mask & ((CELLS'(1) << j) - CELLS'(1));
    return 5'($countones(low));
  endfunction

  // place the free cells' columns side by side and append the target
  function automatic mat_t build_matrix(logic [CELLS-1:0] mask, logic [SYM_W-1:0] target);
    mat_t m;
    logic [4:0] idx;
    m = '0;
    for (int j = 0; j < CELLS; j++) begin
      idx = free_rank(mask, j);
      if (!mask[j] && idx < 5'(FREE)) begin
        for (int i = 0; i < FREE; i++) begin
          m[i][idx[3:0]] = PARITY_COLS[j][i];
        end
      end
    end
    for (int i = 0; i < FREE; i++) begin
      m[i][FREE] = target[i];
    end
    return m;
  endfunction

  // one gauss-jordan column: find a pivot, then clear the column in all other rows
  function automatic elim_t elim_col(mat_t m, logic [3:0] c);
    elim_t r;
    row_t  piv;
    logic  found;
    piv   = m[c];
    found = m[c][c];
    for (int k = 0; k < FREE; k++) begin
      if (k > int'(c) && !found) begin
        piv   = piv ^ m[k];
        found = piv[c];
      end
    end
    for (int k = 0; k < FREE; k++) begin
      if (4'(k) == c) r.m[k] = piv;
      else if (m[k][c]) r.m[k] = m[k] ^ piv;
      else r.m[k] = m[k];
    end
    r.ok = found;
    return r;
  endfunction

  // scatter the solved unknowns back onto their cells
  function automatic logic [CELLS-1:0] scatter(mat_t m, logic [CELLS-1:0] mask);
    logic [CELLS-1:0] res;
    logic [4:0] idx;
    res = '0;
    for (int j = 0; j < CELLS; j++) begin
      idx = free_rank(mask, j);
      if (!mask[j] && idx < 5'(FREE)) res[j] = m[idx[3:0]][FREE];
    end
    return res;
  endfunction

endpackage

### design/wom_second_write_coset_encoder_top.sv
// top level of the second-write coset encoder pipeline
// Accepts one transaction per cycle when the output is not stalled: one stage
// builds the 13x13 system and its target syndrome, thirteen stages each
// eliminate one column of the system, and one output stage scatters the
// solution onto the free cells and sets the status (0 ok, 1 bad fixed mask,
// 2 singular system; on either error the first-write pattern is returned
// unchanged). Every stage holds its own valid bit, so empty stages keep
// taking transactions while a result waits.
module wom_second_write_coset_encoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [wsce_pkg::SYM_W-1:0] in_second_symbol,
  input  logic [wsce_pkg::CELLS-1:0] in_first_pattern,
  input  logic [wsce_pkg::CELLS-1:0] in_fixed_mask,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [wsce_pkg::CELLS-1:0] out_second_pattern,
  output logic [1:0]                 out_status
);
  import wsce_pkg::*;

  logic             valid_r [FREE+1];
  mat_t             mat_r   [FREE+1];
  logic [CELLS-1:0] pat_r   [FREE+1];
  logic [CELLS-1:0] mask_r  [FREE+1];
  logic             bad_r   [FREE+1];
  logic             sing_r  [FREE+1];
  logic             stage_rdy [FREE+1];
  logic             out_rdy;

  logic             out_valid_r;
  logic [CELLS-1:0] out_pat_r;
  status_t          out_status_r;

  mat_t             mat_nxt;
  logic             bad_nxt;
  logic [CELLS-1:0] out_pat_nxt;
  status_t          out_status_nxt;

  // back-pressure: a stage can load when it is empty or its content moves on
  assign out_rdy = !out_valid_r || !out_stall;
  assign stage_rdy[FREE] = !valid_r[FREE] || out_rdy;
  for (genvar g = 0; g < FREE; g++) begin : g_rdy
    assign stage_rdy[g] = !valid_r[g] || stage_rdy[g+1];
  end
  assign in_stall = !stage_rdy[0];

  // mask check, target syndrome and system setup
  always_comb begin
    bad_nxt = ($countones(in_fixed_mask) != FIXED) ||
              ((in_first_pattern & ~in_fixed_mask) != '0);
    mat_nxt = build_matrix(in_fixed_mask, in_second_symbol ^ syndrome(in_first_pattern));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (stage_rdy[0]) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[0]) begin
      mat_r[0]  <= mat_nxt;
      pat_r[0]  <= in_first_pattern;
      mask_r[0] <= in_fixed_mask;
      bad_r[0]  <= bad_nxt;
      sing_r[0] <= 1'b0;
    end
  end

  // one elimination column per stage
  for (genvar g = 0; g < FREE; g++) begin : g_elim
    elim_t step;
    assign step = elim_col(mat_r[g], 4'(g));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g+1] <= 1'b0;
      end else if (stage_rdy[g+1]) begin
        valid_r[g+1] <= valid_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_rdy[g+1]) begin
        mat_r[g+1]  <= step.m;
        pat_r[g+1]  <= pat_r[g];
        mask_r[g+1] <= mask_r[g];
        bad_r[g+1]  <= bad_r[g];
        sing_r[g+1] <= sing_r[g] | !step.ok;
      end
    end
  end

  // status priority and solution scatter
  always_comb begin
    if (bad_r[FREE]) begin
      out_status_nxt = STATUS_BAD_MASK;
      out_pat_nxt    = pat_r[FREE];
    end else if (sing_r[FREE]) begin
      out_status_nxt = STATUS_SINGULAR;
      out_pat_nxt    = pat_r[FREE];
    end else begin
      out_status_nxt = STATUS_OK;
      out_pat_nxt    = pat_r[FREE] | scatter(mat_r[FREE], mask_r[FREE]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= valid_r[FREE];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_pat_r    <= out_pat_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_second_pattern = out_pat_r;
  assign out_status         = out_status_r;

endmodule

### design/wsce_checker.sv
// port-level checker for the second-write coset encoder and its bind
`include "assert_macros.svh"

module wsce_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [wsce_pkg::SYM_W-1:0] in_second_symbol,
  input logic [wsce_pkg::CELLS-1:0] in_first_pattern,
  input logic [wsce_pkg::CELLS-1:0] in_fixed_mask,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [wsce_pkg::CELLS-1:0] out_second_pattern,
  input logic [1:0]                 out_status
);
  import wsce_pkg::*;

  logic [SYM_W+2*CELLS-1:0] in_bus;
  logic [CELLS+1:0]         out_bus;
  logic                     status_known;

  // payloads gathered for the hold checks
  assign in_bus       = {in_second_symbol, in_first_pattern, in_fixed_mask};
  assign out_bus      = {out_second_pattern, out_status};
  assign status_known = (out_status == STATUS_OK) || (out_status == STATUS_BAD_MASK) ||
                        (out_status == STATUS_SINGULAR);

  // a stalled input transaction holds
  `WSCE_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_bus))

  // a stalled result transaction holds
  `WSCE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bus))

  // only defined status codes leave the block
  `WSCE_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status_known)

  // input back-pressure only comes from a full pipe behind a stalled result
  `WSCE_ASSERT_IMP(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind wom_second_write_coset_encoder_top wsce_checker u_wsce_checker (.*);

### bench/tb_wom_second_write_coset_encoder_top.sv
// self-checking bench for the second-write coset encoder: directed and random transactions
module tb_wom_second_write_coset_encoder_top;
  import wsce_pkg::*;

  // expected pattern and status of one transaction
  typedef struct packed {
    logic [CELLS-1:0] cells;
    status_t          code;
  } written_cells_t;

  // predicts the second write of each accepted transaction and checks results in order
  class second_write_tracker;
    written_cells_t pending_writes[$];
    int unsigned    failures;
    int unsigned    mismatches;

    function new();
      failures   = 0;
      mismatches = 0;
    endfunction

    // solve for the free cells that move the syndrome onto the new symbol
    function written_cells_t encode_second_write(logic [SYM_W-1:0] sym,
                                                 logic [CELLS-1:0] first,
                                                 logic [CELLS-1:0] fixed);
      written_cells_t res;
      logic [FREE:0]  eq [FREE];
      logic [SYM_W-1:0] aim;
      int slot;
      res.cells = first;
      res.code  = STATUS_BAD_MASK;
      // mask must fix exactly five cells and cover every cell already set
      if ($countones(fixed) != FIXED || (first & ~fixed) != '0) return res;
      aim = sym;
      for (int j = 0; j < CELLS; j++) begin
        if (first[j]) aim = aim ^ PARITY_COLS[j];
      end
      // one column of unknowns per free cell, target in the top bit
      for (int i = 0; i < FREE; i++) eq[i] = '0;
      slot = 0;
      for (int j = 0; j < CELLS; j++) begin
        if (!fixed[j] && slot < FREE) begin
          for (int i = 0; i < FREE; i++) eq[i][slot] = PARITY_COLS[j][i];
          slot++;
        end
      end
      for (int i = 0; i < FREE; i++) eq[i][FREE] = aim[i];
      // forward pass: pivot row absorbs lower rows until its pivot bit shows up
      for (int c = 0; c < FREE; c++) begin
        for (int k = c + 1; k < FREE; k++) begin
          if (eq[c][c]) break;
          eq[c] = eq[c] ^ eq[k];
        end
        if (!eq[c][c]) begin
          res.code = STATUS_SINGULAR;
          return res;
        end
        for (int k = c + 1; k < FREE; k++) begin
          if (eq[k][c]) eq[k] = eq[k] ^ eq[c];
        end
      end
      // back substitution
      for (int c = 0; c < FREE; c++) begin
        for (int k = 0; k < c; k++) begin
          if (eq[k][c]) eq[k] = eq[k] ^ eq[c];
        end
      end
      // set the solved free cells on top of the first pattern
      slot = 0;
      for (int j = 0; j < CELLS; j++) begin
        if (!fixed[j] && slot < FREE) begin
          res.cells[j] = first[j] | eq[slot][FREE];
          slot++;
        end
      end
      res.code = STATUS_OK;
      return res;
    endfunction

    function void accept_symbol(logic [SYM_W-1:0] sym, logic [CELLS-1:0] first,
                                logic [CELLS-1:0] fixed);
      pending_writes.insert(pending_writes.size(), encode_second_write(sym, first, fixed));
    endfunction

    function void compare_pattern(logic [CELLS-1:0] cells, logic [1:0] code);
      written_cells_t want;
      if (pending_writes.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pattern %h status %0d", cells, code);
        return;
      end
      want = pending_writes.pop_front();
      if (cells !== want.cells || code !== want.code) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pattern exp %h got %h, status exp %0d got %0d",
                   want.cells, cells, want.code, code);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [SYM_W-1:0] in_second_symbol = '0;
  logic [CELLS-1:0] in_first_pattern = '0;
  logic [CELLS-1:0] in_fixed_mask = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CELLS-1:0] out_second_pattern;
  logic [1:0]       out_status;
  bit               calm = 1'b0;
  second_write_tracker tracker = new();

  wom_second_write_coset_encoder_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_second_symbol   (in_second_symbol),
    .in_first_pattern   (in_first_pattern),
    .in_fixed_mask      (in_fixed_mask),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_second_pattern (out_second_pattern),
    .out_status         (out_status)
  );

  // clock
  always #6 clk = ~clk;

  // random result backpressure, off during the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 16);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.compare_pattern(out_second_pattern, out_status);
  end

  // mask with the given number of distinct cells set
  function automatic logic [CELLS-1:0] pick_mask(int bits);
    logic [CELLS-1:0] m;
    m = '0;
    while ($countones(m) < bits) m[$urandom_range(0, CELLS - 1)] = 1'b1;
    return m;
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_cells(logic [SYM_W-1:0] sym, logic [CELLS-1:0] first,
                            logic [CELLS-1:0] fixed);
    while (!calm && $urandom_range(0, 99) < 16) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_second_symbol <= sym;
    in_first_pattern <= first;
    in_fixed_mask    <= fixed;
    do @(posedge clk); while (in_stall);
    tracker.accept_symbol(sym, first, fixed);
  endtask

  // timeout
  initial begin
    #2400000;
    $display("wom_second_write_coset_encoder_top regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    logic [CELLS-1:0] m;
    logic [CELLS-1:0] p;
    int               pick;
    int               b;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and mask corner cases
    send_cells(13'h0000, 18'h00000, 18'h0001F);
    send_cells(13'h1FFF, 18'h0001F, 18'h0001F);
    send_cells(13'h1FFF, 18'h3E000, 18'h3E000);
    send_cells(13'h0AAA, 18'h00000, 18'h3E000);
    send_cells(13'h1555, 18'h00000, 18'h00000);
    send_cells(13'h1FFF, 18'h3FFFF, 18'h3FFFF);
    send_cells(13'h0001, 18'h00000, 18'h0000F);
    send_cells(13'h1000, 18'h0003F, 18'h0003F);
    send_cells(13'h0123, 18'h00020, 18'h0001F);
    send_cells(13'h1FFF, 18'h3FFFF, 18'h0001F);
    send_cells(13'h0000, 18'h20000, 18'h3E000);
    for (int n = 0; n < 12; n++) begin
      m = pick_mask(FIXED);
      send_cells((n % 2) ? 13'h1FFF : 13'h0000, (n % 3 == 0) ? m : '0, m);
    end

    // random: mostly valid masks, the rest broken masks and noise
    for (int n = 0; n < 550; n++) begin
      calm = (n >= 150 && n < 300);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        m = pick_mask(FIXED);
        p = m & CELLS'($urandom);
      end else if (pick < 88) begin
        m = CELLS'($urandom);
        p = CELLS'($urandom);
      end else if (pick < 94) begin
        m = pick_mask($urandom_range(0, 1) ? FIXED - 1 : FIXED + 1);
        p = m & CELLS'($urandom);
      end else begin
        m = pick_mask(FIXED);
        do b = $urandom_range(0, CELLS - 1); while (m[b]);
        p = (m & CELLS'($urandom)) | (CELLS'(1) << b);
      end
      send_cells(SYM_W'($urandom), p, m);
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then allow for the pipeline depth
    while (tracker.pending_writes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_writes.size() == 0) begin
      $display("wom_second_write_coset_encoder_top regression: pass");
    end else begin
      $display("wom_second_write_coset_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
